// ===== src/hbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heightmap bilinear sampler.
// Used by every module of the block; depends on nothing.
package hbs_pkg;

    // Operation codes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SCALE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd3;

    // Height store geometry.
    localparam int STORE_AW = 16;
    localparam int TEXEL_W  = 16;

    // Fixed-point constants.
    localparam int HALF_TEXEL = 32768;
    localparam int NORM_ONE_SHIFT = 14;

    // Shared divider and square root widths.
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;

    // Sample points of one query: centre, left, right, down, up.
    localparam logic [2:0] SMP_C = 3'd0;
    localparam logic [2:0] SMP_L = 3'd1;
    localparam logic [2:0] SMP_R = 3'd2;
    localparam logic [2:0] SMP_D = 3'd3;
    localparam logic [2:0] SMP_U = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [15:0]        load_index;
        logic [15:0]        load_height;
        logic signed [31:0] world_x;
        logic signed [31:0] world_z;
    } in_item_t;

    typedef struct packed {
        logic [23:0]        height;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
        logic [DIV_DW-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    // Which quotient the shared divider is working on.
    typedef enum logic [2:0] {
        DSEL_X  = 3'd0,
        DSEL_Z  = 3'd1,
        DSEL_NX = 3'd2,
        DSEL_NY = 3'd3,
        DSEL_NZ = 3'd4
    } div_sel_t;

endpackage

// ===== src/hbs_store.sv =====
`timescale 1ns / 1ps
// Height texel memory: one write port and one registered read port.
// Depends on hbs_pkg for the geometry constants.
module hbs_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [hbs_pkg::STORE_AW-1:0] wr_addr,
    input  logic [hbs_pkg::TEXEL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [hbs_pkg::STORE_AW-1:0] rd_addr,
    output logic [hbs_pkg::TEXEL_W-1:0]  rd_data
);

    logic [hbs_pkg::TEXEL_W-1:0] mem [2**hbs_pkg::STORE_AW];
    logic [hbs_pkg::TEXEL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data follows in the cycle after the read enable.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/hbs_divider.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on hbs_pkg for the request and response structs.
module hbs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  hbs_pkg::div_req_t req,
    output hbs_pkg::div_rsp_t rsp
);

    localparam int NW = hbs_pkg::DIV_NW;
    localparam int DW = hbs_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // Trial subtraction of one step.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        diff  = trial - {1'b0, dsr_reg};
    end

    // Control: step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/hbs_isqrt.sv =====
`timescale 1ns / 1ps
// Floor integer square root, one result bit per cycle.
// Depends on hbs_pkg for the request and response structs.
module hbs_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  hbs_pkg::sqrt_req_t req,
    output hbs_pkg::sqrt_rsp_t rsp
);

    localparam int W  = hbs_pkg::SQ_W;
    localparam int CW = $clog2(W / 2);

    logic [W-1:0]  v_reg;
    logic [W-1:0]  res_reg;
    logic [W-1:0]  bit_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    // Control: iteration counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(W / 2 - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: classic digit-by-digit root, two radicand bits per step.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            v_reg   <= req.radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(W - 2){1'b0}}};
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[hbs_pkg::ROOT_W-1:0];

endmodule

// ===== src/heightmap_bilinear_sampler_top.sv =====
`timescale 1ns / 1ps
// Heightmap bilinear sampler: a load item is written on acceptance and the next item may
// follow at once. A query takes five passes of the bit-serial divider, texel reads and
// blends on the single memory port, a square root and up to three normalization shifts.
// One query at a time; busy is high until the result strobe, which lasts one cycle and
// cannot be stalled. Reset restores the register defaults; the store stays undefined.
module heightmap_bilinear_sampler_top #(
    parameter int MAP_WIDTH_MAX  = 256,
    parameter int MAP_HEIGHT_MAX = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  hbs_pkg::in_item_t                  item,
    output logic                               result_valid,
    output hbs_pkg::out_item_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LW  = 42;
    localparam int EWW = $clog2(MAP_WIDTH_MAX + 1);
    localparam int EHW = $clog2(MAP_HEIGHT_MAX + 1);
    localparam int TXW = $clog2(MAP_WIDTH_MAX);
    localparam int TZW = $clog2(MAP_HEIGHT_MAX);
    localparam logic signed [LW-1:0] HALF_L = LW'(hbs_pkg::HALF_TEXEL);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_DIV    = 13'b0_0000_0000_0010,
        S_DWAIT  = 13'b0_0000_0000_0100,
        S_RD     = 13'b0_0000_0000_1000,
        S_CAP    = 13'b0_0000_0001_0000,
        S_LERP   = 13'b0_0000_0010_0000,
        S_HMUL   = 13'b0_0000_0100_0000,
        S_NVEC   = 13'b0_0000_1000_0000,
        S_NSHIFT = 13'b0_0001_0000_0000,
        S_SQ     = 13'b0_0010_0000_0000,
        S_SQRT   = 13'b0_0100_0000_0000,
        S_SWAIT  = 13'b0_1000_0000_0000,
        S_HDIV   = 13'b1_0000_0000_0000
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    hbs_pkg::div_sel_t div_sel_reg;
    logic [2:0]        samp_reg;
    logic [1:0]        tex_reg;
    logic [1:0]        step_reg;
    logic              result_valid_reg;
    logic [8:0]        map_width_reg;
    logic [8:0]        map_height_reg;
    logic [15:0]       world_scale_reg;
    logic [15:0]       height_scale_reg;

    // Datapath registers.
    logic signed [31:0]    wx_reg, wz_reg;
    logic signed [LW-1:0]  lx_reg, lz_reg;
    logic [15:0]           t_reg [4];
    logic [15:0]           r0_reg, r1_reg;
    logic [15:0]           ip_reg [5];
    logic [31:0]           hprod_reg;
    logic [15:0]           hq_reg, hr_reg;
    logic [32:0]           m_reg [3];
    logic                  negx_reg, negz_reg;
    logic [59:0]           sq_reg;
    logic [61:0]           acc_reg;
    logic [31:0]           s_reg;
    hbs_pkg::out_item_t    result_reg;

    hbs_pkg::div_req_t  div_req;
    hbs_pkg::div_rsp_t  div_rsp;
    hbs_pkg::sqrt_req_t sq_req;
    hbs_pkg::sqrt_rsp_t sq_rsp;

    logic                 accept;
    logic                 wr_en;
    logic                 rd_en;
    logic [15:0]          rd_addr;
    logic [15:0]          rd_data;
    logic [EWW-1:0]       eff_w;
    logic [EHW-1:0]       eff_h;
    logic [15:0]          ws_eff;
    logic signed [LW-1:0] sx, sz;
    logic [27:0]          xs, zs;
    logic [TXW-1:0]       tx;
    logic [TZW-1:0]       tz;
    logic [31:0]          lin;
    logic [15:0]          la, lb, lf;
    logic signed [16:0]   ldiff;
    logic signed [33:0]   lprod;
    logic signed [17:0]   lsum;
    logic [15:0]          nhi, nlo, nmag;
    logic                 big;
    logic                 qneg;
    logic signed [LW-1:0] qpos, qfloor;
    logic [15:0]          q16;
    logic [31:0]          absx, absz;
    logic [32:0]          hq_sum;
    logic [31:0]          hr_full;
    logic [24:0]          hf_sum;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign wr_en     = accept && (item.operation == hbs_pkg::OP_LOAD);
    assign cfg_ready = 1'b1;

    // Effective map size and world scale.
    always_comb
    begin
        if (map_width_reg == '0)
            eff_w = EWW'(1);
        else if (32'(map_width_reg) > 32'(MAP_WIDTH_MAX))
            eff_w = EWW'(MAP_WIDTH_MAX);
        else
            eff_w = EWW'(map_width_reg);
        if (map_height_reg == '0)
            eff_h = EHW'(1);
        else if (32'(map_height_reg) > 32'(MAP_HEIGHT_MAX))
            eff_h = EHW'(MAP_HEIGHT_MAX);
        else
            eff_h = EHW'(map_height_reg);
        ws_eff = (world_scale_reg == '0) ? 16'd1 : world_scale_reg;
    end

    // Sample position, edge clamp and row-major texel address.
    always_comb
    begin
        sx = lx_reg;
        sz = lz_reg;
        unique case (samp_reg)
            hbs_pkg::SMP_L: sx = lx_reg - HALF_L;
            hbs_pkg::SMP_R: sx = lx_reg + HALF_L;
            hbs_pkg::SMP_D: sz = lz_reg - HALF_L;
            hbs_pkg::SMP_U: sz = lz_reg + HALF_L;
            default:
            begin
                sx = lx_reg;
                sz = lz_reg;
            end
        endcase
        xs = {{2{sx[LW-1]}}, sx[LW-1:16]} + 28'(tex_reg[0]);
        zs = {{2{sz[LW-1]}}, sz[LW-1:16]} + 28'(tex_reg[1]);
        if (xs[27])
            tx = '0;
        else if (xs > 28'(eff_w) - 28'd1)
            tx = TXW'(eff_w - EWW'(1));
        else
            tx = xs[TXW-1:0];
        if (zs[27])
            tz = '0;
        else if (zs > 28'(eff_h) - 28'd1)
            tz = TZW'(eff_h - EHW'(1));
        else
            tz = zs[TZW-1:0];
        lin     = 32'(tz) * 32'(eff_w) + 32'(tx);
        rd_addr = lin[15:0];
        rd_en   = (state_reg == S_RD);
    end

    // Linear blend a + (b - a) * f / 65536 with floor, exact for 16-bit fractions.
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                la = t_reg[0];
                lb = t_reg[1];
                lf = sx[15:0];
            end
            2'd1:
            begin
                la = t_reg[2];
                lb = t_reg[3];
                lf = sx[15:0];
            end
            default:
            begin
                la = r0_reg;
                lb = r1_reg;
                lf = sz[15:0];
            end
        endcase
        ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
        lprod = ldiff * $signed({1'b0, lf});
        lsum  = $signed({2'b00, la}) + $signed(lprod[33:16]);
    end

    // Height scaling by 256 / 65535. For x below 2^32 the quotient of x / 65535 is
    // (x + 1 + (x >> 16)) >> 16; the product is split into quotient and remainder
    // first, then the remainder times 256 is divided the same way.
    always_comb
    begin
        hq_sum  = {1'b0, hprod_reg} + 33'(hprod_reg[31:16]) + 33'd1;
        hr_full = hprod_reg - {hq_sum[31:16], 16'd0} + 32'(hq_sum[31:16]);
        hf_sum  = {1'b0, hr_reg, 8'd0} + 25'(hr_reg[15:8]) + 25'd1;
    end

    // Slope magnitude of one axis for the normal.
    always_comb
    begin
        if (step_reg == 2'd0)
        begin
            nhi = ip_reg[hbs_pkg::SMP_R];
            nlo = ip_reg[hbs_pkg::SMP_L];
        end
        else
        begin
            nhi = ip_reg[hbs_pkg::SMP_U];
            nlo = ip_reg[hbs_pkg::SMP_D];
        end
        nmag = (nhi >= nlo) ? (nhi - nlo) : (nlo - nhi);
        big  = (m_reg[0][32:30] != '0) || (m_reg[1][32:30] != '0) ||
               (m_reg[2][32:30] != '0);
    end

    // Floor division fix-up of the world coordinate quotient.
    always_comb
    begin
        qneg   = (div_sel_reg == hbs_pkg::DSEL_X) ? wx_reg[31] : wz_reg[31];
        qpos   = $signed({1'b0, div_rsp.quotient[LW-2:0]});
        if (qneg)
            qfloor = -(qpos + ((div_rsp.remainder != '0) ? LW'(1) : LW'(0)));
        else
            qfloor = qpos;
        q16  = div_rsp.quotient[15:0];
        absx = wx_reg[31] ? 32'(-wx_reg) : 32'(wx_reg);
        absz = wz_reg[31] ? 32'(-wz_reg) : 32'(wz_reg);
    end

    // Divider operand selection.
    always_comb
    begin
        div_req.start = (state_reg == S_DIV);
        unique case (div_sel_reg)
            hbs_pkg::DSEL_X:
            begin
                div_req.dividend = {8'd0, absx, 8'd0};
                div_req.divisor  = 32'(ws_eff);
            end
            hbs_pkg::DSEL_Z:
            begin
                div_req.dividend = {8'd0, absz, 8'd0};
                div_req.divisor  = 32'(ws_eff);
            end
            hbs_pkg::DSEL_NX:
            begin
                div_req.dividend = {4'd0, m_reg[0][29:0], 14'd0} + 48'(s_reg[31:1]);
                div_req.divisor  = s_reg;
            end
            hbs_pkg::DSEL_NY:
            begin
                div_req.dividend = {4'd0, m_reg[1][29:0], 14'd0} + 48'(s_reg[31:1]);
                div_req.divisor  = s_reg;
            end
            default:
            begin
                div_req.dividend = {4'd0, m_reg[2][29:0], 14'd0} + 48'(s_reg[31:1]);
                div_req.divisor  = s_reg;
            end
        endcase
        sq_req.start    = (state_reg == S_SQRT);
        sq_req.radicand = {2'b00, acc_reg};
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && (item.operation == hbs_pkg::OP_QUERY))
                    state_next = S_DIV;
            S_DIV:
                state_next = S_DWAIT;
            S_DWAIT:
                if (div_rsp.done)
                begin
                    unique case (div_sel_reg)
                        hbs_pkg::DSEL_Z: state_next = S_RD;
                        hbs_pkg::DSEL_NZ: state_next = S_IDLE;
                        default: state_next = S_DIV;
                    endcase
                end
            S_RD:
                state_next = S_CAP;
            S_CAP:
                state_next = (tex_reg == 2'd3) ? S_LERP : S_RD;
            S_LERP:
                if (step_reg == 2'd2)
                    state_next = (samp_reg == hbs_pkg::SMP_U) ? S_HMUL : S_RD;
            S_HMUL:
                state_next = S_HDIV;
            S_HDIV:
                state_next = S_NVEC;
            S_NVEC:
                if (step_reg == 2'd1)
                    state_next = S_NSHIFT;
            S_NSHIFT:
                if (!big)
                    state_next = S_SQ;
            S_SQ:
                if (step_reg == 2'd3)
                    state_next = S_SQRT;
            S_SQRT:
                state_next = S_SWAIT;
            S_SWAIT:
                if (sq_rsp.done)
                    state_next = S_DIV;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers, configuration and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            div_sel_reg      <= hbs_pkg::DSEL_X;
            samp_reg         <= hbs_pkg::SMP_C;
            tex_reg          <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
            map_width_reg    <= 9'd256;
            map_height_reg   <= 9'd256;
            world_scale_reg  <= 16'd256;
            height_scale_reg <= 16'd256;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hbs_pkg::CFG_MAP_WIDTH:   map_width_reg    <= cfg_data[8:0];
                    hbs_pkg::CFG_MAP_HEIGHT:  map_height_reg   <= cfg_data[8:0];
                    hbs_pkg::CFG_WORLD_SCALE: world_scale_reg  <= cfg_data;
                    default:                  height_scale_reg <= cfg_data;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                    div_sel_reg <= hbs_pkg::DSEL_X;
                S_DWAIT:
                    if (div_rsp.done)
                    begin
                        unique case (div_sel_reg)
                            hbs_pkg::DSEL_X:  div_sel_reg <= hbs_pkg::DSEL_Z;
                            hbs_pkg::DSEL_Z:
                            begin
                                samp_reg <= hbs_pkg::SMP_C;
                                tex_reg  <= '0;
                            end
                            hbs_pkg::DSEL_NX: div_sel_reg <= hbs_pkg::DSEL_NY;
                            hbs_pkg::DSEL_NY: div_sel_reg <= hbs_pkg::DSEL_NZ;
                            default:          result_valid_reg <= 1'b1;
                        endcase
                    end
                S_CAP:
                begin
                    tex_reg <= tex_reg + 1'b1;
                    if (tex_reg == 2'd3)
                        step_reg <= '0;
                end
                S_LERP:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        samp_reg <= samp_reg + 1'b1;
                        tex_reg  <= '0;
                    end
                end
                S_HDIV:
                    step_reg <= '0;
                S_NVEC:
                    step_reg <= step_reg + 1'b1;
                S_NSHIFT:
                    step_reg <= '0;
                S_SQ:
                    step_reg <= step_reg + 1'b1;
                S_SWAIT:
                    div_sel_reg <= hbs_pkg::DSEL_NX;
                default:
                    step_reg <= step_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wx_reg <= item.world_x;
            wz_reg <= item.world_z;
        end

        unique case (state_reg)
            S_DWAIT:
                if (div_rsp.done)
                begin
                    unique case (div_sel_reg)
                        hbs_pkg::DSEL_X:  lx_reg <= qfloor - HALF_L;
                        hbs_pkg::DSEL_Z:  lz_reg <= qfloor - HALF_L;
                        hbs_pkg::DSEL_NX:
                            result_reg.normal_x <= negx_reg ? -$signed(q16) : $signed(q16);
                        hbs_pkg::DSEL_NY:
                            result_reg.normal_y <= $signed(q16);
                        default:
                            result_reg.normal_z <= negz_reg ? -$signed(q16) : $signed(q16);
                    endcase
                end
            S_CAP:
                t_reg[tex_reg] <= rd_data;
            S_LERP:
            begin
                unique case (step_reg)
                    2'd0: r0_reg <= lsum[15:0];
                    2'd1: r1_reg <= lsum[15:0];
                    default: ip_reg[samp_reg] <= lsum[15:0];
                endcase
            end
            S_HMUL:
                hprod_reg <= ip_reg[hbs_pkg::SMP_C] * height_scale_reg;
            S_HDIV:
            begin
                hq_reg <= hq_sum[31:16];
                hr_reg <= hr_full[15:0];
            end
            S_NVEC:
            begin
                if (step_reg == 2'd0)
                begin
                    result_reg.height <= {hq_reg, hf_sum[23:16]};
                    m_reg[0] <= 33'(nmag * height_scale_reg);
                    negx_reg <= (nhi > nlo) && (height_scale_reg != '0);
                    m_reg[1] <= {ws_eff, 17'd0} - {16'd0, ws_eff, 1'b0};
                end
                else
                begin
                    m_reg[2] <= 33'(nmag * height_scale_reg);
                    negz_reg <= (nhi > nlo) && (height_scale_reg != '0);
                end
            end
            S_NSHIFT:
                if (big)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
            S_SQ:
            begin
                if (step_reg != 2'd3)
                    sq_reg <= m_reg[step_reg][29:0] * m_reg[step_reg][29:0];
                if (step_reg == 2'd0)
                    acc_reg <= '0;
                else
                    acc_reg <= acc_reg + 62'(sq_reg);
            end
            S_SWAIT:
                if (sq_rsp.done)
                    s_reg <= (sq_rsp.root == '0) ? 32'd1 : sq_rsp.root;
            default:
                s_reg <= s_reg;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    hbs_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.load_index),
        .wr_data (item.load_height),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hbs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hbs_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

endmodule
